FILE: hw/rtl/acc_cpu_pkg.sv
// ============================================================================
// acc_cpu_pkg
// Shared constants for the accumulator processor execute core.
// ============================================================================
package acc_cpu_pkg;

    // Field widths
    localparam int FUNC_W    = 4;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Default data memory depth
    localparam int DATA_DEPTH_DEF = 256;

    // Opcodes
    localparam logic [FUNC_W-1:0] OP_LOADMEM = 4'd0;
    localparam logic [FUNC_W-1:0] OP_LOADVAL = 4'd1;
    localparam logic [FUNC_W-1:0] OP_STORE   = 4'd2;
    localparam logic [FUNC_W-1:0] OP_ADD     = 4'd3;
    localparam logic [FUNC_W-1:0] OP_SUB     = 4'd4;
    localparam logic [FUNC_W-1:0] OP_MUL     = 4'd5;
    localparam logic [FUNC_W-1:0] OP_DIV     = 4'd6;
    localparam logic [FUNC_W-1:0] OP_INC     = 4'd7;
    localparam logic [FUNC_W-1:0] OP_DEC     = 4'd8;
    localparam logic [FUNC_W-1:0] OP_AND     = 4'd9;
    localparam logic [FUNC_W-1:0] OP_OR      = 4'd10;
    localparam logic [FUNC_W-1:0] OP_NOT     = 4'd11;
    localparam logic [FUNC_W-1:0] OP_JMP     = 4'd12;
    localparam logic [FUNC_W-1:0] OP_JZ      = 4'd13;
    localparam logic [FUNC_W-1:0] OP_JNZ     = 4'd14;
    localparam logic [FUNC_W-1:0] OP_HLT     = 4'd15;

    // Run status codes
    localparam logic [STATUS_W-1:0] RUN_ACTIVE = 2'd0;
    localparam logic [STATUS_W-1:0] RUN_HALTED = 2'd1;
    localparam logic [STATUS_W-1:0] RUN_DIV0   = 2'd2;

    // Divider control group
    typedef struct packed {
        logic             start;
        logic [BYTE_W-1:0] dividend;
        logic [BYTE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [BYTE_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hw/rtl/accumulator_cpu_execute_core.sv
// ============================================================================
// accumulator_cpu_execute_core
// Execute core of an 8-bit accumulator processor with a cleared data memory.
// ============================================================================
// Usage:
//   Each item on the slave stream is one fetched instruction (opcode and
//   operand). The core executes it against the accumulator, the flags and the
//   data memory and returns exactly one item on the master stream: next
//   instruction index, accumulator, zero/carry/overflow flags and run status.
//   Each instruction passes through the memory read on acceptance, operand
//   capture and commit; a DIV with a nonzero divisor also runs the bit-serial
//   divider loop between operand capture and commit. One instruction
//   is in flight at a time, since each depends on the accumulator the last
//   one left; the next item is taken the cycle after commit, so the core
//   cannot take a new item before it is through with the last one.
//   A finished result waits in the output register while the next item is
//   accepted; if the receiver stalls, the commit of that next item waits.
//   Reset clears the accumulator, counter, flags and status, and marks every
//   data memory byte invalid so it reads as zero until stored.
//   After HLT or a divide by zero every item returns the stored state.
// ============================================================================
module accumulator_cpu_execute_core
    import acc_cpu_pkg::*;
#(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: func[3:0], operand[11:4], zero padding [15:12]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: next_pc[7:0], acc_value[15:8], zero_flag[16], carry_flag[17],
    //          overflow_flag[18], run_status[20:19], zero padding [23:21]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);
    // Reciprocal for operand mod DATA_DEPTH, exact for 8-bit operands
    localparam int RECIP  = (65536 + DATA_DEPTH - 1) / DATA_DEPTH;

    localparam logic [1:0] FSM_IDLE = 2'd0;
    localparam logic [1:0] FSM_EXEC = 2'd1;
    localparam logic [1:0] FSM_DIV  = 2'd2;
    localparam logic [1:0] FSM_CALC = 2'd3;

    logic [1:0]          fsm_reg, fsm_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [BYTE_W-1:0]   opnd_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [BYTE_W-1:0]   mval_reg;
    logic [BYTE_W-1:0]   acc_reg, acc_next;
    logic [BYTE_W-1:0]   pc_reg, pc_next;
    logic                zero_reg, zero_next;
    logic                carry_reg, carry_next;
    logic                ovf_reg, ovf_next;
    logic [STATUS_W-1:0] stop_reg, stop_next;
    logic [DATA_DEPTH-1:0] vld_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                accept;
    logic                out_free;
    logic                commit;
    logic [FUNC_W-1:0]   in_func;
    logic [BYTE_W-1:0]   in_opnd;
    logic [24:0]         recip_prod;
    logic [BYTE_W-1:0]   in_quot;
    logic [15:0]         quot_back;
    logic [15:0]         in_rem;
    logic [ADDR_W-1:0]   in_addr;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   mem_val;
    logic                mem_we;
    logic [BYTE_W:0]     add_sum;
    logic [15:0]         mul_prod;
    logic                may_latch;
    logic                upd;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // Unpack input item
    assign in_func = s_tdata[FUNC_W-1:0];
    assign in_opnd = s_tdata[FUNC_W +: BYTE_W];

    // Reduce operand modulo the memory depth
    assign recip_prod = {17'b0, in_opnd} * 25'(RECIP);
    assign in_quot    = recip_prod[23:16];
    assign quot_back  = {8'b0, in_quot} * 16'(DATA_DEPTH);
    assign in_rem     = {8'b0, in_opnd} - quot_back;
    assign in_addr    = in_rem[ADDR_W-1:0];

    // Handshakes
    assign s_tready = (fsm_reg == FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (fsm_reg == FSM_CALC) && out_free;

    // Data memory, read issued on acceptance
    acc_cpu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (acc_reg),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Never-written bytes read as zero
    assign mem_val = vld_reg[addr_reg] ? ram_rdata : '0;

    // Divider request issued from the operand-capture cycle
    assign div_req.start    = (fsm_reg == FSM_EXEC) && (stop_reg == RUN_ACTIVE) &&
                              (func_reg == OP_DIV) && (mem_val != '0);
    assign div_req.dividend = acc_reg;
    assign div_req.divisor  = mem_val;

    acc_cpu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequence one instruction
    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE: if (accept) fsm_next = FSM_EXEC;
            FSM_EXEC: fsm_next = div_req.start ? FSM_DIV : FSM_CALC;
            FSM_DIV:  if (div_rsp.done) fsm_next = FSM_CALC;
            FSM_CALC: if (out_free) fsm_next = FSM_IDLE;
            default:  fsm_next = FSM_IDLE;
        endcase
    end

    // Execute and compute the new architectural state
    always_comb begin
        add_sum    = {1'b0, acc_reg} + {1'b0, mval_reg};
        mul_prod   = {8'b0, acc_reg} * {8'b0, mval_reg};
        may_latch  = !carry_reg && !ovf_reg;
        acc_next   = acc_reg;
        pc_next    = pc_reg + 8'd1;
        zero_next  = zero_reg;
        carry_next = carry_reg;
        ovf_next   = ovf_reg;
        stop_next  = stop_reg;
        mem_we     = 1'b0;
        upd        = 1'b1;
        if (stop_reg != RUN_ACTIVE) begin
            upd = 1'b0;
        end else begin
            unique case (func_reg)
                OP_LOADMEM: acc_next = mval_reg;
                OP_LOADVAL: acc_next = opnd_reg;
                OP_STORE:   mem_we = commit;
                OP_ADD: begin
                    if (add_sum[BYTE_W] && may_latch) carry_next = 1'b1;
                    acc_next = add_sum[BYTE_W-1:0];
                end
                OP_SUB:     acc_next = acc_reg - mval_reg;
                OP_MUL: begin
                    if ((mul_prod[15:8] != '0) && may_latch) ovf_next = 1'b1;
                    acc_next = mul_prod[BYTE_W-1:0];
                end
                OP_DIV: begin
                    if (mval_reg == '0) begin
                        stop_next = RUN_DIV0;
                        upd       = 1'b0;
                    end else begin
                        acc_next = div_rsp.quotient;
                    end
                end
                OP_INC: begin
                    if ((acc_reg == 8'hFF) && may_latch) carry_next = 1'b1;
                    acc_next = acc_reg + 8'd1;
                end
                OP_DEC:     acc_next = acc_reg - 8'd1;
                OP_AND:     acc_next = acc_reg & mval_reg;
                OP_OR:      acc_next = acc_reg | mval_reg;
                OP_NOT:     acc_next = ~acc_reg;
                OP_JMP:     pc_next = {1'b0, opnd_reg[BYTE_W-1:1]};
                OP_JZ:      if (acc_reg == '0) pc_next = {1'b0, opnd_reg[BYTE_W-1:1]};
                OP_JNZ:     if (acc_reg != '0) pc_next = {1'b0, opnd_reg[BYTE_W-1:1]};
                OP_HLT: begin
                    stop_next = RUN_HALTED;
                    upd       = 1'b0;
                end
                default:    upd = 1'b0;
            endcase
        end
        if (upd) begin
            zero_next = (acc_next == '0);
        end else begin
            acc_next = acc_reg;
            pc_next  = pc_reg;
        end
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= FSM_IDLE;
            acc_reg      <= '0;
            pc_reg       <= '0;
            zero_reg     <= 1'b0;
            carry_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            stop_reg     <= RUN_ACTIVE;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fsm_reg <= fsm_next;
            if (commit) begin
                acc_reg   <= acc_next;
                pc_reg    <= pc_next;
                zero_reg  <= zero_next;
                carry_reg <= carry_next;
                ovf_reg   <= ovf_next;
                stop_reg  <= stop_next;
            end
            if (mem_we) begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= in_func;
            opnd_reg <= in_opnd;
            addr_reg <= in_addr;
        end
        if (fsm_reg == FSM_EXEC) begin
            mval_reg <= mem_val;
        end
        if (commit) begin
            m_tdata_reg <= {3'b0, stop_next, ovf_next, carry_next, zero_next,
                            acc_next, pc_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hw/rtl/acc_cpu_ram.sv
// ============================================================================
// acc_cpu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module acc_cpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/acc_cpu_div.sv
// ============================================================================
// acc_cpu_div
// Restoring 8-bit unsigned divider, one quotient bit per cycle.
// ============================================================================
module acc_cpu_div
    import acc_cpu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [3:0] LAST_STEP = 4'(BYTE_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [BYTE_W-1:0] rem_reg, rem_next;
    logic [BYTE_W-1:0] quo_reg, quo_next;
    logic [BYTE_W-1:0] dsr_reg, dsr_next;
    logic [BYTE_W:0]   shifted;
    logic [BYTE_W:0]   diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted   = {rem_reg, quo_reg[BYTE_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[BYTE_W-1:0];
                quo_next = {quo_reg[BYTE_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[BYTE_W-1:0];
                quo_next = {quo_reg[BYTE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: test/accumulator_cpu_execute_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// accumulator_cpu_execute_core_test
// Self-checking bench for the accumulator processor execute core. Fetched
// instructions go in on the slave stream with random gaps, and results are
// taken with random stalls. A behavioral model of the processor state
// (accumulator, counter, flags, status, data memory) predicts each result,
// and the results are checked in order. The run ends with a halt or a
// divide by zero, followed by a few instructions that must be ignored.
// ============================================================================
module accumulator_cpu_execute_core_test;
    import acc_cpu_pkg::*;

    // One result item as carried on m_tdata
    typedef struct packed {
        logic [BYTE_W-1:0]   next_pc;
        logic [BYTE_W-1:0]   acc_value;
        logic                zero_flag;
        logic                carry_flag;
        logic                overflow_flag;
        logic [STATUS_W-1:0] run_status;
    } cpu_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted processor state
    logic [BYTE_W-1:0]   acc_q;
    logic [BYTE_W-1:0]   pc_q;
    logic                zero_q;
    logic                carry_q;
    logic                ovf_q;
    logic [STATUS_W-1:0] status_q;
    logic [BYTE_W-1:0]   data_mem [0:DATA_DEPTH_DEF-1];

    logic [S_TDATA_W-1:0] pending_instrs[$];
    cpu_result_t          predicted_results[$];

    int  issued_count  = 0;
    int  taken_count   = 0;
    int  retired_count = 0;
    int  fail_count    = 0;
    int  gap_left      = 0;
    int  stall_left    = 0;
    bit  instr_taken   = 1'b0;
    bit  send_idle_on  = 1'b1;
    bit  recv_idle_on  = 1'b1;

    accumulator_cpu_execute_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Execute one instruction on the predicted state and queue its result
    task execute_instr(input logic [FUNC_W-1:0] op, input logic [BYTE_W-1:0] opnd);
        logic [BYTE_W-1:0]   mem_byte;
        logic [BYTE_W-1:0]   acc_n;
        logic [BYTE_W-1:0]   pc_n;
        logic [BYTE_W:0]     sum;
        logic [2*BYTE_W-1:0] prod;
        logic                may_latch;
        cpu_result_t         res;
        begin
            mem_byte  = data_mem[opnd];
            acc_n     = acc_q;
            pc_n      = pc_q + 8'd1;
            may_latch = !carry_q && !ovf_q;
            sum       = {1'b0, acc_q} + {1'b0, mem_byte};
            prod      = acc_q * mem_byte;
            if (status_q == RUN_ACTIVE) begin
                case (op)
                    OP_LOADMEM: acc_n = mem_byte;
                    OP_LOADVAL: acc_n = opnd;
                    OP_STORE:   data_mem[opnd] = acc_q;
                    OP_ADD: begin
                        if (sum[BYTE_W] && may_latch) carry_q = 1'b1;
                        acc_n = sum[BYTE_W-1:0];
                    end
                    OP_SUB: acc_n = acc_q - mem_byte;
                    OP_MUL: begin
                        if (prod > 16'd255 && may_latch) ovf_q = 1'b1;
                        acc_n = prod[BYTE_W-1:0];
                    end
                    OP_DIV: begin
                        if (mem_byte == 8'd0) status_q = RUN_DIV0;
                        else acc_n = acc_q / mem_byte;
                    end
                    OP_INC: begin
                        if (acc_q == 8'hFF && may_latch) carry_q = 1'b1;
                        acc_n = acc_q + 8'd1;
                    end
                    OP_DEC: acc_n = acc_q - 8'd1;
                    OP_AND: acc_n = acc_q & mem_byte;
                    OP_OR:  acc_n = acc_q | mem_byte;
                    OP_NOT: acc_n = ~acc_q;
                    OP_JMP: pc_n = opnd >> 1;
                    OP_JZ:  if (acc_q == 8'd0) pc_n = opnd >> 1;
                    OP_JNZ: if (acc_q != 8'd0) pc_n = opnd >> 1;
                    default: status_q = RUN_HALTED;
                endcase
                // A stop leaves accumulator, counter and flags untouched
                if (status_q == RUN_ACTIVE) begin
                    acc_q  = acc_n;
                    pc_q   = pc_n;
                    zero_q = (acc_n == 8'd0);
                end
            end
            res.next_pc       = pc_q;
            res.acc_value     = acc_q;
            res.zero_flag     = zero_q;
            res.carry_flag    = carry_q;
            res.overflow_flag = ovf_q;
            res.run_status    = status_q;
            predicted_results.push_back(res);
        end
    endtask

    // Take an instruction off the slave stream and predict its result
    always @(posedge aclk) begin
        instr_taken = aresetn && s_tvalid && s_tready;
        if (instr_taken) begin
            execute_instr(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W+BYTE_W-1:FUNC_W]);
            taken_count++;
        end
    end

    // Drive the next pending item, with random gaps between items
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || instr_taken) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (pending_instrs.size() > 0) begin
                s_tdata  <= pending_instrs.pop_front();
                s_tvalid <= 1'b1;
                gap_left = (send_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result stream at random
    always @(negedge aclk) begin
        if (stall_left == 0 && recv_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each result against the oldest prediction
    always @(posedge aclk) begin
        cpu_result_t got;
        cpu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.next_pc       = m_tdata[7:0];
            got.acc_value     = m_tdata[15:8];
            got.zero_flag     = m_tdata[16];
            got.carry_flag    = m_tdata[17];
            got.overflow_flag = m_tdata[18];
            got.run_status    = m_tdata[20:19];
            if (predicted_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: result with nothing expected: pc=%0d acc=%0d z=%0b c=%0b v=%0b st=%0d",
                             $time, got.next_pc, got.acc_value, got.zero_flag,
                             got.carry_flag, got.overflow_flag, got.run_status);
                end
            end else begin
                want = predicted_results.pop_front();
                retired_count++;
                if (got.next_pc !== want.next_pc || got.acc_value !== want.acc_value ||
                    got.zero_flag !== want.zero_flag || got.carry_flag !== want.carry_flag ||
                    got.overflow_flag !== want.overflow_flag ||
                    got.run_status !== want.run_status) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result %0d: expected pc=%0d acc=%0d z=%0b c=%0b v=%0b st=%0d",
                                 $time, retired_count, want.next_pc, want.acc_value,
                                 want.zero_flag, want.carry_flag, want.overflow_flag,
                                 want.run_status);
                        $display("%0t: result %0d: got      pc=%0d acc=%0d z=%0b c=%0b v=%0b st=%0d",
                                 $time, retired_count, got.next_pc, got.acc_value,
                                 got.zero_flag, got.carry_flag, got.overflow_flag,
                                 got.run_status);
                    end
                end
            end
        end
    end

    task send_instr(input logic [FUNC_W-1:0] op, input logic [BYTE_W-1:0] opnd);
        begin
            pending_instrs.push_back({4'b0000, opnd, op});
            issued_count++;
        end
    endtask

    // Hold off until every issued item has been accepted
    task wait_all_taken();
        begin
            wait (taken_count == issued_count);
        end
    endtask

    // Divide by a memory byte that is known to be nonzero at that point
    task send_divide(input logic [BYTE_W-1:0] opnd);
        logic [BYTE_W-1:0] addr;
        int                tries;
        begin
            wait_all_taken();
            addr = opnd;
            for (tries = 0; tries < 8 && data_mem[addr] == 8'd0; tries++) begin
                addr = 8'($urandom_range(0, 255));
            end
            if (data_mem[addr] == 8'd0) begin
                send_instr(OP_LOADVAL, 8'($urandom_range(1, 255)));
                send_instr(OP_STORE, addr);
            end
            send_instr(OP_DIV, addr);
        end
    endtask

    initial begin
        int                i;
        int                latch_pick;
        logic [FUNC_W-1:0] op;
        logic [BYTE_W-1:0] opnd;

        acc_q    = '0;
        pc_q     = '0;
        zero_q   = 1'b0;
        carry_q  = 1'b0;
        ovf_q    = 1'b0;
        status_q = RUN_ACTIVE;
        for (i = 0; i < DATA_DEPTH_DEF; i++) begin
            data_mem[i] = '0;
        end

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every opcode but HLT, operand extremes, jumps taken and not taken
        send_instr(OP_LOADMEM, 8'd0);
        send_instr(OP_LOADVAL, 8'd255);
        send_instr(OP_STORE,   8'd255);
        send_instr(OP_LOADVAL, 8'd1);
        send_instr(OP_STORE,   8'd0);
        send_instr(OP_ADD,     8'd0);
        send_instr(OP_SUB,     8'd255);
        send_instr(OP_MUL,     8'd0);
        send_instr(OP_DEC,     8'd0);
        send_instr(OP_INC,     8'd255);
        send_instr(OP_AND,     8'd255);
        send_instr(OP_OR,      8'd0);
        send_instr(OP_NOT,     8'd0);
        send_instr(OP_JMP,     8'd255);
        send_instr(OP_JZ,      8'd0);
        send_instr(OP_JNZ,     8'd254);
        send_instr(OP_LOADVAL, 8'd0);
        send_instr(OP_JZ,      8'd2);
        send_instr(OP_JNZ,     8'd255);
        send_instr(OP_LOADVAL, 8'd200);
        send_instr(OP_DIV,     8'd0);
        send_instr(OP_DIV,     8'd255);
        send_instr(OP_LOADVAL, 8'd255);
        // First sticky event: carry from add, carry from increment, or overflow
        latch_pick = $urandom_range(0, 2);
        case (latch_pick)
            0:       send_instr(OP_ADD, 8'd0);
            1:       send_instr(OP_INC, 8'd0);
            default: send_instr(OP_MUL, 8'd255);
        endcase
        // A second event must not latch the other flag
        send_instr(OP_LOADVAL, 8'd255);
        send_instr((latch_pick == 2) ? OP_ADD : OP_MUL, 8'd255);

        // Random programs, no halt until the end
        for (i = 0; i < 1100; i++) begin
            if (i % 64 == 0) begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            // Pause once until the core has drained completely
            if (i == 550) begin
                wait_all_taken();
                wait (retired_count == taken_count);
            end
            op   = 4'($urandom_range(0, 14));
            opnd = 8'($urandom_range(0, 255));
            if (op == OP_DIV) begin
                send_divide(opnd);
            end else begin
                send_instr(op, opnd);
            end
            if (pending_instrs.size() > 16) begin
                wait (pending_instrs.size() <= 4);
            end
        end

        // Stop the core by a halt or by a zero divisor
        if ($urandom_range(0, 1) == 0) begin
            send_instr(OP_HLT, 8'($urandom_range(0, 255)));
        end else begin
            wait_all_taken();
            opnd = 8'($urandom_range(0, 255));
            if (data_mem[opnd] != 8'd0) begin
                send_instr(OP_LOADVAL, 8'd0);
                send_instr(OP_STORE, opnd);
            end
            send_instr(OP_DIV, opnd);
        end
        // Everything after a stop must be ignored
        for (i = 0; i < 10; i++) begin
            send_instr(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end

        wait_all_taken();
        wait (retired_count == taken_count);
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
